>>> rtl/pmzm_pkg.sv
// Package: shared constants, types and helpers of the position message zone matcher.
`timescale 1ns / 1ps
package pmzm_pkg;

    localparam int COORD_BITS = 24;
    localparam int ZONE_COUNT = 64;
    localparam int ZONE_IDX_W = 6;
    localparam int RADIUS_W   = COORD_BITS - 1;
    localparam int ISS_W      = ZONE_IDX_W + 1;
    localparam int FC_W       = 4;
    localparam int VEH_MAX    = 7;
    localparam int NUM_MAX    = 9;
    localparam int HEAD_LEN   = 4;
    localparam int TRAIL_LEN  = 3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // magnitude limit 2^(COORD_BITS-1)
    localparam logic [COORD_BITS-1:0] MAG_LIM = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_VEH   = 3'd1,
        PH_X     = 3'd2,
        PH_Y     = 3'd3,
        PH_TRAIL = 3'd4,
        PH_DEAD  = 3'd5
    } t_phase;

    typedef enum logic {
        SR_IDLE = 1'b0,
        SR_SCAN = 1'b1
    } t_srch_state;

    // end-of-message event from parser to search
    typedef struct packed {
        logic                         done;
        logic                         complete;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_msg_evt;

    // one result beat
    typedef struct packed {
        logic                         complete;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         zone_hit;
        logic [ZONE_IDX_W-1:0]        zone_label;
        logic                         label_valid;
    } t_result;

    function automatic logic [7:0] head_char(input logic [FC_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h61; // a
            4'd3:    c = 8'h64; // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trail_char(input logic [FC_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h45; // E
            4'd1:    c = 8'h6E; // n
            4'd2:    c = 8'h64; // d
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // saturated signed value from magnitude (magnitude never exceeds MAG_LIM)
    function automatic logic [COORD_BITS-1:0] finish_num(input logic [COORD_BITS-1:0] mag,
                                                         input logic neg);
        logic [COORD_BITS-1:0] v;
        if (neg) begin
            v = (mag > MAG_LIM) ? MAG_LIM : mag;
            v = ~v + 1'b1;
        end else begin
            v = (mag > POS_MAX) ? POS_MAX : mag;
        end
        return v;
    endfunction

endpackage

>>> rtl/pmzm_ifs.sv
// Interfaces: input and result channels of the position message zone matcher.
`timescale 1ns / 1ps
interface pmzm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   mode;
    logic [7:0]                             msg_byte;
    logic                                   msg_last;
    logic [pmzm_pkg::ZONE_IDX_W-1:0]        zone_index;
    logic signed [pmzm_pkg::COORD_BITS-1:0] zone_x;
    logic signed [pmzm_pkg::COORD_BITS-1:0] zone_y;

    modport source (output valid, mode, msg_byte, msg_last, zone_index, zone_x, zone_y,
                    input ready);
    modport sink   (input valid, mode, msg_byte, msg_last, zone_index, zone_x, zone_y,
                    output ready);
endinterface

interface pmzm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   complete;
    logic signed [pmzm_pkg::COORD_BITS-1:0] pos_x;
    logic signed [pmzm_pkg::COORD_BITS-1:0] pos_y;
    logic                                   zone_hit;
    logic [pmzm_pkg::ZONE_IDX_W-1:0]        zone_label;
    logic                                   label_valid;

    modport source (output valid, complete, pos_x, pos_y, zone_hit, zone_label, label_valid,
                    input ready);
    modport sink   (input valid, complete, pos_x, pos_y, zone_hit, zone_label, label_valid,
                    output ready);
endinterface

>>> rtl/pmzm_parser.sv
// Message parser: byte-wise header, vehicle, x, y and trailer decode.
`timescale 1ns / 1ps
module pmzm_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_vld,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output pmzm_pkg::t_msg_evt o_evt
);
    localparam int CB = pmzm_pkg::COORD_BITS;
    localparam int FW = pmzm_pkg::FC_W;

    pmzm_pkg::t_phase r_phase, n_phase;
    logic [FW-1:0]    r_fc, n_fc;
    logic             r_hdr_ok, n_hdr_ok;
    logic             r_trl_ok, n_trl_ok;
    logic             r_ovf, n_ovf;
    logic             r_sign, n_sign;
    logic             r_stop, n_stop;
    logic [CB-1:0]    r_acc_x, n_acc_x;
    logic [CB-1:0]    r_acc_y, n_acc_y;

    logic [CB-1:0]    cur_acc;
    logic [CB-1:0]    dig_acc;
    logic [CB+3:0]    prod;
    logic             is_digit;
    logic             fc_sat;
    logic             msg_done;

    assign fc_sat   = (r_fc == {FW{1'b1}});
    assign is_digit = (i_byte >= pmzm_pkg::CH_ZERO) && (i_byte <= pmzm_pkg::CH_NINE);
    assign cur_acc  = (r_phase == pmzm_pkg::PH_X) ? r_acc_x : r_acc_y;

    // acc*10 + digit, clamped to the magnitude limit
    always_comb begin
        prod = {cur_acc, 3'b000} + {2'b00, cur_acc, 1'b0}
             + {{(CB-4){1'b0}}, i_byte[3:0] - pmzm_pkg::CH_ZERO[3:0]};
        dig_acc = (prod > {4'b0000, pmzm_pkg::MAG_LIM}) ? pmzm_pkg::MAG_LIM : prod[CB-1:0];
    end

    // next parse state for one message byte
    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_hdr_ok = r_hdr_ok;
        n_trl_ok = r_trl_ok;
        n_ovf    = r_ovf;
        n_sign   = r_sign;
        n_stop   = r_stop;
        n_acc_x  = r_acc_x;
        n_acc_y  = r_acc_y;
        if (i_byte_vld && (i_byte != pmzm_pkg::CH_NUL)) begin
            case (r_phase)
                pmzm_pkg::PH_HEAD: begin
                    if (i_byte == pmzm_pkg::CH_PLUS) begin
                        if (r_hdr_ok && (r_fc == FW'(pmzm_pkg::HEAD_LEN))) begin
                            n_phase = pmzm_pkg::PH_VEH;
                            n_fc    = '0;
                        end else begin
                            n_phase = pmzm_pkg::PH_DEAD;
                        end
                    end else begin
                        if ((r_fc >= FW'(pmzm_pkg::HEAD_LEN)) ||
                            (pmzm_pkg::head_char(r_fc) != i_byte)) begin
                            n_hdr_ok = 1'b0;
                        end
                        if (!fc_sat) n_fc = r_fc + 1'b1;
                    end
                end
                pmzm_pkg::PH_VEH: begin
                    if (i_byte == pmzm_pkg::CH_USCORE) begin
                        n_phase = pmzm_pkg::PH_X;
                        n_fc    = '0;
                        n_sign  = 1'b0;
                        n_stop  = 1'b0;
                    end else if (r_fc >= FW'(pmzm_pkg::VEH_MAX)) begin
                        n_ovf   = 1'b1;
                        n_phase = pmzm_pkg::PH_DEAD;
                    end else begin
                        n_fc = r_fc + 1'b1;
                    end
                end
                pmzm_pkg::PH_X, pmzm_pkg::PH_Y: begin
                    if ((r_phase == pmzm_pkg::PH_X) && (i_byte == pmzm_pkg::CH_USCORE)) begin
                        n_acc_x = pmzm_pkg::finish_num(r_acc_x, r_sign);
                        n_phase = pmzm_pkg::PH_Y;
                        n_fc    = '0;
                        n_sign  = 1'b0;
                        n_stop  = 1'b0;
                    end else if ((r_phase == pmzm_pkg::PH_Y) &&
                                 (i_byte == pmzm_pkg::CH_PLUS)) begin
                        n_acc_y = pmzm_pkg::finish_num(r_acc_y, r_sign);
                        n_phase = pmzm_pkg::PH_TRAIL;
                        n_fc    = '0;
                    end else if (r_fc >= FW'(pmzm_pkg::NUM_MAX)) begin
                        n_ovf   = 1'b1;
                        n_phase = pmzm_pkg::PH_DEAD;
                    end else begin
                        if ((r_fc == '0) && ((i_byte == pmzm_pkg::CH_MINUS) ||
                                             (i_byte == pmzm_pkg::CH_PLUS))) begin
                            n_sign = (i_byte == pmzm_pkg::CH_MINUS);
                        end else if (!r_stop && is_digit) begin
                            if (r_phase == pmzm_pkg::PH_X) n_acc_x = dig_acc;
                            else                           n_acc_y = dig_acc;
                        end else begin
                            n_stop = 1'b1;
                        end
                        n_fc = r_fc + 1'b1;
                    end
                end
                pmzm_pkg::PH_TRAIL: begin
                    if ((r_fc >= FW'(pmzm_pkg::TRAIL_LEN)) ||
                        (pmzm_pkg::trail_char(r_fc) != i_byte)) begin
                        n_trl_ok = 1'b0;
                    end
                    if (!fc_sat) n_fc = r_fc + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // end-of-message event
    always_comb begin
        msg_done       = i_byte_vld && ((i_byte == pmzm_pkg::CH_NUL) || i_last);
        o_evt.done     = msg_done;
        o_evt.complete = (n_phase == pmzm_pkg::PH_TRAIL) && n_hdr_ok && n_trl_ok &&
                         (n_fc == FW'(pmzm_pkg::TRAIL_LEN)) && !n_ovf;
        o_evt.x        = n_acc_x;
        o_evt.y        = n_acc_y;
    end

    // state registers; a message end restarts the parse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || msg_done) begin
            r_phase  <= pmzm_pkg::PH_HEAD;
            r_fc     <= '0;
            r_hdr_ok <= 1'b1;
            r_trl_ok <= 1'b1;
            r_ovf    <= 1'b0;
            r_sign   <= 1'b0;
            r_stop   <= 1'b0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_hdr_ok <= n_hdr_ok;
            r_trl_ok <= n_trl_ok;
            r_ovf    <= n_ovf;
            r_sign   <= n_sign;
            r_stop   <= n_stop;
            r_acc_x  <= n_acc_x;
            r_acc_y  <= n_acc_y;
        end
    end
endmodule

>>> rtl/pmzm_zone_search.sv
// Zone table memory, ordered radius search pipeline and result register.
`timescale 1ns / 1ps
module pmzm_zone_search (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [pmzm_pkg::ZONE_IDX_W-1:0]        i_wr_idx,
    input  logic signed [pmzm_pkg::COORD_BITS-1:0] i_wr_x,
    input  logic signed [pmzm_pkg::COORD_BITS-1:0] i_wr_y,
    input  logic [pmzm_pkg::RADIUS_W-1:0]          i_radius,
    input  pmzm_pkg::t_msg_evt                     i_evt,
    input  logic                                   i_res_ready,
    output logic                                   o_busy,
    output logic                                   o_res_valid,
    output pmzm_pkg::t_result                      o_res
);
    localparam int CB = pmzm_pkg::COORD_BITS;
    localparam int RW = pmzm_pkg::RADIUS_W;
    localparam int IW = pmzm_pkg::ZONE_IDX_W;
    localparam int SW = pmzm_pkg::ISS_W;

    logic [2*CB-1:0] r_mem [pmzm_pkg::ZONE_COUNT];
    logic [pmzm_pkg::ZONE_COUNT-1:0] r_written;

    pmzm_pkg::t_srch_state r_state, n_state;
    logic [SW-1:0]   r_iss;
    logic            issue;
    logic [2*CB-1:0] r_rd_data;
    logic            r_v1, r_v2, r_v3;
    logic            r_wr1, r_wr2, r_wr3;
    logic [IW-1:0]   r_idx1, r_idx2, r_idx3;
    logic [RW-1:0]   r_ax, r_ay;
    logic            r_inr2, r_inr3;
    logic [2*RW-1:0] r_x2, r_y2, r_r2;
    logic signed [CB-1:0] r_held_x, r_held_y;
    logic [IW-1:0]   r_label;
    logic            r_label_vld;
    logic            r_out_vld;
    pmzm_pkg::t_result r_out;

    logic signed [CB:0] dx, dy;
    logic [CB:0]     ax, ay;
    logic [2*RW:0]   dist2;
    logic            match3;
    logic            scan_end;
    logic            start_scan;
    logic            load_miss;

    // zone table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && ({1'b0, i_wr_idx} < SW'(pmzm_pkg::ZONE_COUNT))) begin
            r_mem[i_wr_idx] <= {i_wr_x, i_wr_y};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_iss[IW-1:0]];
        end
    end

    // written flag per table entry; unwritten entries never match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_idx] <= 1'b1;
        end
    end

    // stage 2: absolute differences and per-axis range check
    always_comb begin
        dx = {r_held_x[CB-1], r_held_x} - {r_rd_data[2*CB-1], r_rd_data[2*CB-1:CB]};
        dy = {r_held_y[CB-1], r_held_y} - {r_rd_data[CB-1], r_rd_data[CB-1:0]};
        ax = dx[CB] ? (~dx + 1'b1) : dx;
        ay = dy[CB] ? (~dy + 1'b1) : dy;
    end

    // stage 4 compare: x^2 + y^2 <= r^2
    assign dist2  = {1'b0, r_x2} + {1'b0, r_y2};
    assign match3 = r_v3 && r_wr3 && r_inr3 && (dist2 <= {1'b0, r_r2});

    assign start_scan = i_evt.done && i_evt.complete;
    assign load_miss  = i_evt.done && !i_evt.complete;
    assign scan_end   = (r_state == pmzm_pkg::SR_SCAN) && r_v3 &&
                        (match3 || (r_idx3 == IW'(pmzm_pkg::ZONE_COUNT - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pmzm_pkg::SR_IDLE: if (start_scan) n_state = pmzm_pkg::SR_SCAN;
            pmzm_pkg::SR_SCAN: if (scan_end)   n_state = pmzm_pkg::SR_IDLE;
            default:                           n_state = pmzm_pkg::SR_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        issue  = (r_state == pmzm_pkg::SR_SCAN) && !scan_end &&
                 (r_iss < SW'(pmzm_pkg::ZONE_COUNT));
        o_busy = (r_state != pmzm_pkg::SR_IDLE);
    end

    // search pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmzm_pkg::SR_IDLE;
            r_iss   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_scan || scan_end) begin
                r_iss <= '0;
                r_v1  <= 1'b0;
                r_v2  <= 1'b0;
                r_v3  <= 1'b0;
            end else begin
                if (issue) r_iss <= r_iss + 1'b1;
                r_v1 <= issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // search pipeline data
    always_ff @(posedge i_clk) begin
        r_idx1 <= r_iss[IW-1:0];
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_wr1  <= r_written[r_iss[IW-1:0]];
        r_wr2  <= r_wr1;
        r_wr3  <= r_wr2;
        r_inr2 <= (ax <= {2'b00, i_radius}) && (ay <= {2'b00, i_radius});
        r_ax   <= ax[RW-1:0];
        r_ay   <= ay[RW-1:0];
        r_inr3 <= r_inr2;
        r_x2   <= r_ax * r_ax;
        r_y2   <= r_ay * r_ay;
        r_r2   <= i_radius * i_radius;
    end

    // held position and label
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_label     <= '0;
            r_label_vld <= 1'b0;
        end else begin
            if (start_scan) begin
                r_held_x <= i_evt.x;
                r_held_y <= i_evt.y;
            end
            if (scan_end && match3) begin
                r_label     <= r_idx3;
                r_label_vld <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_miss || scan_end) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_miss) begin
            r_out.complete    <= 1'b0;
            r_out.pos_x       <= r_held_x;
            r_out.pos_y       <= r_held_y;
            r_out.zone_hit    <= 1'b0;
            r_out.zone_label  <= r_label;
            r_out.label_valid <= r_label_vld;
        end else if (scan_end) begin
            r_out.complete    <= 1'b1;
            r_out.pos_x       <= r_held_x;
            r_out.pos_y       <= r_held_y;
            r_out.zone_hit    <= match3;
            r_out.zone_label  <= match3 ? r_idx3 : r_label;
            r_out.label_valid <= r_label_vld || match3;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
endmodule

>>> rtl/position_message_zone_matcher.sv
// Top level: position message zone matcher.
//
//  channel  | dir | handshake          | beat
//  i_in     | in  | valid/ready        | mode, msg_byte, msg_last, zone_index, zone_x, zone_y
//  o_out    | out | valid/ready        | complete, pos_x, pos_y, zone_hit, zone_label, label_valid
//  i_cfg_*  | in  | write enable only  | match_radius
//
// Message bytes and table writes are taken back to back unless the input is held. A
// message end that starts a zone search holds the input until the search ends; the
// single read port of the zone memory walks entries in order through a
// four-stage distance pipeline. Reset is synchronous; the zone table is not
// cleared, its written flags are. A pending result does not block input,
// except a message end.
`timescale 1ns / 1ps
module position_message_zone_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pmzm_in_if.sink                         i_in,
    pmzm_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [pmzm_pkg::RADIUS_W-1:0]   i_cfg_wdata
);
    logic [pmzm_pkg::RADIUS_W-1:0] r_radius;
    logic                          acc;
    logic                          ends_msg;
    logic                          busy;
    logic                          res_vld;
    pmzm_pkg::t_result             res;
    pmzm_pkg::t_msg_evt            evt;

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_radius <= '0;
        else if (i_cfg_we) r_radius <= i_cfg_wdata;
    end

    // a message end needs a free result slot
    assign ends_msg   = !i_in.mode && ((i_in.msg_byte == pmzm_pkg::CH_NUL) || i_in.msg_last);
    assign i_in.ready = !busy && !(ends_msg && res_vld && !o_out.ready);
    assign acc        = i_in.valid && i_in.ready;

    pmzm_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (acc && !i_in.mode),
        .i_byte     (i_in.msg_byte),
        .i_last     (i_in.msg_last),
        .o_evt      (evt)
    );

    pmzm_zone_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (acc && i_in.mode),
        .i_wr_idx    (i_in.zone_index),
        .i_wr_x      (i_in.zone_x),
        .i_wr_y      (i_in.zone_y),
        .i_radius    (r_radius),
        .i_evt       (evt),
        .i_res_ready (o_out.ready),
        .o_busy      (busy),
        .o_res_valid (res_vld),
        .o_res       (res)
    );

    assign o_out.valid       = res_vld;
    assign o_out.complete    = res.complete;
    assign o_out.pos_x       = res.pos_x;
    assign o_out.pos_y       = res.pos_y;
    assign o_out.zone_hit    = res.zone_hit;
    assign o_out.zone_label  = res.zone_label;
    assign o_out.label_valid = res.label_valid;
endmodule

>>> rtl/pmzm_checker.sv
// Port-level checker for the position message zone matcher, with its bind.
`timescale 1ns / 1ps
module pmzm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_mode,
    input logic [7:0] i_msg_byte,
    input logic       i_msg_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_complete,
    input logic       i_zone_hit,
    input logic       i_label_valid
);
    // a result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before taken");

    // a hit only comes from a complete message and marks the label valid
    a_hit_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zone_hit |-> i_complete && i_label_valid)
        else $error("zone hit without complete message or valid label");

    // a message end is never taken while a result is stuck
    a_end_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_mode &&
        ((i_msg_byte == pmzm_pkg::CH_NUL) || i_msg_last)
        |-> !i_out_valid || i_out_ready)
        else $error("message end accepted with result slot full");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind position_message_zone_matcher pmzm_checker u_pmzm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_mode        (i_in.mode),
    .i_msg_byte    (i_in.msg_byte),
    .i_msg_last    (i_in.msg_last),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_complete    (o_out.complete),
    .i_zone_hit    (o_out.zone_hit),
    .i_label_valid (o_out.label_valid)
);

>>> test/pmzm_tb_ifs.sv
// Testbench package: drain time after the last expected result.
`timescale 1ns / 1ps
package pmzm_tb_pkg;
    localparam int DRAIN_CYCLES = 80;
endpackage

>>> test/tb_position_message_zone_matcher.sv
// Testbench: drives position messages and zone writes, checks results against a predictor.
`timescale 1ns / 1ps
module tb_position_message_zone_matcher;
    import pmzm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [RADIUS_W-1:0] cfg_wdata;

    pmzm_in_if  in_ch();
    pmzm_out_if out_ch();

    position_message_zone_matcher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [RADIUS_W-1:0] radius;
    t_phase phase;
    int unsigned fcount;
    bit head_good, trail_good, overflow, neg, stopped;
    longint ax_acc, ay_acc, hx, hy;
    int unsigned hlabel;
    bit hlabel_valid;
    longint zx[ZONE_COUNT];
    longint zy[ZONE_COUNT];
    bit zwritten[ZONE_COUNT];
    bit last_complete;

    t_result expected_results[$];
    int errors;
    int idle_count;

    localparam longint MAG = 64'sd1 <<< (COORD_BITS - 1);

    function automatic void clear_message();
        phase = PH_HEAD; fcount = 0; head_good = 1; trail_good = 1;
        overflow = 0; neg = 0; stopped = 0; ax_acc = 0; ay_acc = 0;
    endfunction

    function automatic longint saturate(longint m);
        if (neg) return -((m > MAG) ? MAG : m);
        return (m > MAG - 1) ? MAG - 1 : m;
    endfunction

    function automatic void bump();
        if (fcount < 15) fcount++;
    endfunction

    function automatic void digit_char(ref longint acc, input logic [7:0] c);
        longint m;
        if (fcount >= NUM_MAX) begin
            overflow = 1; phase = PH_DEAD; return;
        end
        if (fcount == 0 && (c == CH_MINUS || c == CH_PLUS)) begin
            neg = (c == CH_MINUS);
        end else if (!stopped && c >= CH_ZERO && c <= CH_NINE) begin
            m = acc * 10 + (c - CH_ZERO);
            acc = (m > MAG) ? MAG : m;
        end else begin
            stopped = 1;
        end
        bump();
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (phase)
            PH_HEAD: begin
                if (c == CH_PLUS) begin
                    if (head_good && fcount == HEAD_LEN) begin
                        phase = PH_VEH; fcount = 0;
                    end else phase = PH_DEAD;
                end else begin
                    if (fcount >= HEAD_LEN || head_char(fcount[3:0]) != c) head_good = 0;
                    bump();
                end
            end
            PH_VEH: begin
                if (c == CH_USCORE) begin
                    phase = PH_X; fcount = 0; neg = 0; stopped = 0;
                end else if (fcount >= VEH_MAX) begin
                    overflow = 1; phase = PH_DEAD;
                end else bump();
            end
            PH_X: begin
                if (c == CH_USCORE) begin
                    ax_acc = saturate(ax_acc);
                    phase = PH_Y; fcount = 0; neg = 0; stopped = 0;
                end else digit_char(ax_acc, c);
            end
            PH_Y: begin
                if (c == CH_PLUS) begin
                    ay_acc = saturate(ay_acc);
                    phase = PH_TRAIL; fcount = 0;
                end else digit_char(ay_acc, c);
            end
            PH_TRAIL: begin
                if (fcount >= TRAIL_LEN || trail_char(fcount[3:0]) != c) trail_good = 0;
                bump();
            end
            default: ;
        endcase
    endfunction

    function automatic bit in_zone(int j);
        longint dx, dy, r;
        dx = hx - zx[j]; dy = hy - zy[j];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        r = radius;
        if (dx > r || dy > r) return 0;
        return dx * dx + dy * dy <= r * r;
    endfunction

    // advance the predictor by one accepted beat; queue a result if one is due
    function automatic void predict_beat(bit mode, logic [7:0] c, bit last, int idx,
                                         logic signed [COORD_BITS-1:0] x,
                                         logic signed [COORD_BITS-1:0] y);
        t_result res;
        bit done, hit;
        if (mode) begin
            zx[idx] = x; zy[idx] = y; zwritten[idx] = 1;
            return;
        end
        if (c != CH_NUL) parse_char(c);
        if (c != CH_NUL && !last) return;
        done = (phase == PH_TRAIL) && head_good && trail_good && fcount == TRAIL_LEN
               && !overflow;
        hit = 0;
        if (done) begin
            hx = ax_acc; hy = ay_acc;
            for (int j = 0; j < ZONE_COUNT; j++) begin
                if (zwritten[j] && in_zone(j)) begin
                    hit = 1; hlabel = j; hlabel_valid = 1; break;
                end
            end
        end
        res.complete = done;
        res.pos_x = hx[COORD_BITS-1:0];
        res.pos_y = hy[COORD_BITS-1:0];
        res.zone_hit = hit;
        res.zone_label = hlabel[ZONE_IDX_W-1:0];
        res.label_valid = hlabel_valid;
        expected_results.push_back(res);
        last_complete = done;
        clear_message();
    endfunction

    // input beat buffer
    typedef struct {
        bit mode;
        logic [7:0] c;
        bit last;
        int idx;
        logic signed [COORD_BITS-1:0] x, y;
    } t_beat;
    t_beat pending[$];

    // drop valid for a random gap, mostly none or short
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_beat(t_beat b);
        in_ch.valid <= 1'b1;
        in_ch.mode <= b.mode;
        in_ch.msg_byte <= b.c;
        in_ch.msg_last <= b.last;
        in_ch.zone_index <= b.idx[ZONE_IDX_W-1:0];
        in_ch.zone_x <= b.x;
        in_ch.zone_y <= b.y;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beat(b.mode, b.c, b.last, b.idx, b.x, b.y);
        if ($urandom_range(0, 3) == 0) idle_gap();
    endtask

    task automatic flush_beats();
        t_beat b;
        while (pending.size() > 0) begin
            b = pending.pop_front();
            send_beat(b);
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_zone(int idx, longint x, longint y);
        t_beat b;
        b.mode = 1; b.c = 8'($urandom); b.last = 1'($urandom); b.idx = idx;
        b.x = x[COORD_BITS-1:0]; b.y = y[COORD_BITS-1:0];
        pending.push_back(b);
    endtask

    task automatic queue_text(string s, bit use_last);
        t_beat b;
        for (int i = 0; i < s.len(); i++) begin
            b.mode = 0; b.c = s[i]; b.idx = $urandom_range(0, 63);
            b.x = COORD_BITS'($urandom); b.y = COORD_BITS'($urandom);
            b.last = use_last && (i == s.len() - 1);
            pending.push_back(b);
        end
        if (!use_last) begin
            b.mode = 0; b.c = CH_NUL; b.last = 1'($urandom); pending.push_back(b);
        end
    endtask

    task automatic wait_idle();
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (pmzm_tb_pkg::DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_radius(logic [RADIUS_W-1:0] r);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        radius = r;
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 9))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        if ($urandom_range(0, 15) == 0) s = {s, "a1"};
        return s;
    endfunction

    function automatic string rand_message();
        string s, num_y;
        int k;
        k = $urandom_range(0, 7);
        s = "Head+";
        for (int i = 0; i < k; i++) s = {s, string'(8'($urandom_range(65, 90)))};
        num_y = rand_number();
        if (num_y[0] == "+") num_y = num_y.substr(1, num_y.len() - 1);
        if (num_y.len() == 0) num_y = "7";
        s = {s, "_", rand_number(), "_", num_y, "+End"};
        case ($urandom_range(0, 11))
            0: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
            1: s = s.substr(0, $urandom_range(0, s.len() - 2));
            2: s = {s, "x"};
            default: ;
        endcase
        return s;
    endfunction

    // sink side: random stalls, compare against oldest expectation
    initial begin
        t_result e;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 30) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.complete !== e.complete) begin
                        $error("complete exp %0d got %0d", e.complete, out_ch.complete);
                        errors++;
                    end
                    if (out_ch.pos_x !== e.pos_x) begin
                        $error("pos_x exp %0d got %0d", e.pos_x, out_ch.pos_x);
                        errors++;
                    end
                    if (out_ch.pos_y !== e.pos_y) begin
                        $error("pos_y exp %0d got %0d", e.pos_y, out_ch.pos_y);
                        errors++;
                    end
                    if (out_ch.zone_hit !== e.zone_hit) begin
                        $error("zone_hit exp %0d got %0d", e.zone_hit, out_ch.zone_hit);
                        errors++;
                    end
                    if (out_ch.zone_label !== e.zone_label) begin
                        $error("zone_label exp %0d got %0d", e.zone_label, out_ch.zone_label);
                        errors++;
                    end
                    if (out_ch.label_valid !== e.label_valid) begin
                        $error("label_valid exp %0d got %0d", e.label_valid,
                               out_ch.label_valid);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    initial begin
        idle_count = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // directed rows: text, and the expected complete flag read straight off the format
    typedef struct {
        string text;
        bit use_last;
        int want_complete;
    } t_row;
    t_row directed[] = '{
        '{"Head+V_0_0+End", 1, 1},
        '{"Head+ABCDEFG_-8388608_8388607+End", 0, 1},
        '{"Head+A_999999999_-999999999+End", 1, 0},
        '{"Head+A_+12a3_-x+End", 0, 1},
        '{"Head+ABCDEFGH_1_1+End", 1, 0},
        '{"Head+A_1234567890_1+End", 1, 0},
        '{"Heda+A_1_1+End", 1, 0},
        '{"Head+A_1_1+Ends", 0, 0},
        '{"Head+A_1", 1, 0},
        '{"", 0, 0},
        '{"Head+A_5_5+End", 1, 1},
        '{"Head+_--5_7+End", 1, 1}
    };

    initial begin
        longint r;
        errors = 0;
        radius = '0;
        last_complete = 0;
        clear_message();
        hx = 0; hy = 0; hlabel = 0; hlabel_valid = 0;
        for (int j = 0; j < ZONE_COUNT; j++) zwritten[j] = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.msg_last = 1'b0;
        in_ch.zone_index = '0;
        in_ch.zone_x = '0;
        in_ch.zone_y = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zones at extremes, then table rows with typed completion flag
        set_radius('0);
        queue_zone(0, 0, 0);
        queue_zone(63, -8388608, 8388607);
        queue_zone(5, 5, 5);
        flush_beats();
        foreach (directed[i]) begin
            queue_text(directed[i].text, directed[i].use_last);
            flush_beats();
            if (int'(last_complete) != directed[i].want_complete) begin
                $error("complete exp %0d got %0d", directed[i].want_complete, last_complete);
                errors++;
            end
            wait_idle();
        end
        set_radius({RADIUS_W{1'b1}});
        queue_text("Head+Q_100_-100+End", 1);
        flush_beats();
        wait_idle();

        // random: rotate radius between extremes and random values
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_radius('0);
                1: set_radius({RADIUS_W{1'b1}});
                2: set_radius(RADIUS_W'($urandom_range(0, 2000)));
                default: set_radius(RADIUS_W'($urandom));
            endcase
            for (int n = 0; n < 5; n++) begin
                r = $urandom_range(0, 3) == 0 ? longint'($signed(24'($urandom)))
                                              : longint'($urandom_range(0, 4000)) - 2000;
                queue_zone(int'($urandom_range(0, 63)), r,
                           longint'($urandom_range(0, 4000)) - 2000);
            end
            while (pending.size() < 60) queue_text(rand_message(), 1'($urandom_range(0, 1)));
            flush_beats();
            wait_idle();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
rtl/pmzm_pkg.sv
rtl/pmzm_ifs.sv
rtl/pmzm_parser.sv
rtl/pmzm_zone_search.sv
rtl/position_message_zone_matcher.sv
rtl/pmzm_checker.sv
test/pmzm_tb_ifs.sv
test/tb_position_message_zone_matcher.sv
